// ----- hdl/lflr_pkg.sv -----
// Shared constants, command codes and the result bundle of the LFU tracker.
`timescale 1ns / 1ps

package lflr_pkg;

    localparam int LFLR_ENTRIES    = 64;
    localparam int LFLR_COUNT_BITS = 16;
    localparam int LFLR_KEY_BITS   = 64;

    // Fixed widths of the port fields
    localparam int KEY_PORT_BITS = 64;
    localparam int CAP_BITS      = 7;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 7'd64;

    // Request commands
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef struct packed {
        logic                     hit;
        logic                     evicted_valid;
        logic [KEY_PORT_BITS-1:0] evict_key;
    } lflr_res_t;

endpackage

// ----- hdl/lflr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps

module lflr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/lflr_engine.sv -----
// Entry table sequencer: clear sweep, lookup/victim scan, rank and count update sweep.
`timescale 1ns / 1ps

module lflr_engine
    import lflr_pkg::*;
#(
    parameter int ENTRIES    = LFLR_ENTRIES,
    parameter int COUNT_BITS = LFLR_COUNT_BITS,
    parameter int KEY_BITS   = LFLR_KEY_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            start_cmd,
    input  logic [KEY_BITS-1:0]             start_key,
    output logic                            busy,
    input  logic [$clog2(ENTRIES+1)-1:0]    eff_cap,
    input  logic                            res_ready,
    output logic                            res_push,
    output lflr_res_t                       res,
    output logic [$clog2(ENTRIES+1)-1:0]    total
);

    localparam int IDX_BITS  = $clog2(ENTRIES);
    localparam int OCC_BITS  = $clog2(ENTRIES + 1);
    localparam int RANK_BITS = IDX_BITS;
    localparam int WORD_BITS = 1 + KEY_BITS + COUNT_BITS + RANK_BITS;
    localparam int COUNT_LSB = RANK_BITS;
    localparam int KEY_LSB   = RANK_BITS + COUNT_BITS;
    localparam int VALID_BIT = WORD_BITS - 1;
    localparam logic [IDX_BITS-1:0]   IDX_LAST  = IDX_BITS'(ENTRIES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_SCAN_END = 3'd3;
    localparam logic [2:0] ST_DECIDE   = 3'd4;
    localparam logic [2:0] ST_UPDATE   = 3'd5;
    localparam logic [2:0] ST_UPD_END  = 3'd6;
    localparam logic [2:0] ST_RESULT   = 3'd7;

    // Control registers
    logic [2:0]          state_reg, state_next;
    logic [IDX_BITS-1:0] addr_reg, addr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [OCC_BITS-1:0] total_reg, total_next;

    // Request and scan results
    logic [IDX_BITS-1:0]   rd_pos_reg, rd_pos_next;
    logic                  cmd_reg, cmd_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic                  found_reg, found_next;
    logic [IDX_BITS-1:0]   s_idx_reg, s_idx_next;
    logic [RANK_BITS-1:0]  s_rank_reg, s_rank_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_BITS-1:0]   free_idx_reg, free_idx_next;
    logic                  vic_found_reg, vic_found_next;
    logic [IDX_BITS-1:0]   vic_idx_reg, vic_idx_next;
    logic [COUNT_BITS-1:0] vic_count_reg, vic_count_next;
    logic [RANK_BITS-1:0]  vic_rank_reg, vic_rank_next;
    logic [KEY_BITS-1:0]   vic_key_reg, vic_key_next;

    // Update plan
    logic                 close_en_reg, close_en_next;
    logic [RANK_BITS-1:0] close_rank_reg, close_rank_next;
    logic                 kill_en_reg, kill_en_next;
    logic [IDX_BITS-1:0]  kill_idx_reg, kill_idx_next;
    logic                 bump_en_reg, bump_en_next;
    logic                 ins_en_reg, ins_en_next;
    logic [IDX_BITS-1:0]  ins_idx_reg, ins_idx_next;
    logic [RANK_BITS-1:0] new_rank_reg, new_rank_next;

    // Result
    logic                hit_reg, hit_next;
    logic                ev_valid_reg, ev_valid_next;
    logic [KEY_BITS-1:0] ev_key_reg, ev_key_next;

    // Memory ports
    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [WORD_BITS-1:0] rd_data;

    logic                  rd_valid;
    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_count;
    logic [RANK_BITS-1:0]  rd_rank;
    logic                  scan_take;
    logic                  upd_take;
    logic                  beats;
    logic                  must_evict;
    logic                  vic_ok;
    logic [IDX_BITS-1:0]   slot_for_ins;
    logic                  nv;
    logic [KEY_BITS-1:0]   nk;
    logic [COUNT_BITS-1:0] nc;
    logic [RANK_BITS-1:0]  nr;

    lflr_ram #(
        .WIDTH(WORD_BITS),
        .DEPTH(ENTRIES)
    ) u_table (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(addr_reg),
        .rd_data(rd_data)
    );

    assign rd_valid = rd_data[VALID_BIT];
    assign rd_key   = rd_data[KEY_LSB +: KEY_BITS];
    assign rd_count = rd_data[COUNT_LSB +: COUNT_BITS];
    assign rd_rank  = rd_data[RANK_BITS-1:0];

    assign scan_take = rd_vld_reg && ((state_reg == ST_SCAN) || (state_reg == ST_SCAN_END));
    assign upd_take  = rd_vld_reg && ((state_reg == ST_UPDATE) || (state_reg == ST_UPD_END));

    // Lowest count wins, oldest access breaks a tie
    assign beats = rd_valid && (!vic_found_reg || (rd_count < vic_count_reg) ||
                   ((rd_count == vic_count_reg) && (rd_rank < vic_rank_reg)));

    assign must_evict = ((OCC_BITS + 1)'(total_reg) + (OCC_BITS + 1)'(1)) >
                        (OCC_BITS + 1)'(eff_cap);
    assign vic_ok = vic_found_reg && (vic_count_reg <= COUNT_ONE);
    assign slot_for_ins = (free_found_reg && (free_idx_reg < vic_idx_reg)) ?
                          free_idx_reg : vic_idx_reg;

    // Rewrite of one entry during the update sweep
    always_comb
    begin
        nv = rd_valid;
        nk = rd_key;
        nc = rd_count;
        nr = rd_rank;
        if (close_en_reg && rd_valid && (rd_rank > close_rank_reg))
        begin
            nr = rd_rank - RANK_BITS'(1);
        end
        if (kill_en_reg && (rd_pos_reg == kill_idx_reg))
        begin
            nv = 1'b0;
        end
        if (bump_en_reg && (rd_pos_reg == s_idx_reg))
        begin
            nr = new_rank_reg;
            nc = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_ONE;
        end
        if (ins_en_reg && (rd_pos_reg == ins_idx_reg))
        begin
            nv = 1'b1;
            nk = key_reg;
            nc = COUNT_ONE;
            nr = new_rank_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        total_next      = total_reg;
        rd_pos_next     = addr_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        found_next      = found_reg;
        s_idx_next      = s_idx_reg;
        s_rank_next     = s_rank_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_count_next  = vic_count_reg;
        vic_rank_next   = vic_rank_reg;
        vic_key_next    = vic_key_reg;
        close_en_next   = close_en_reg;
        close_rank_next = close_rank_reg;
        kill_en_next    = kill_en_reg;
        kill_idx_next   = kill_idx_reg;
        bump_en_next    = bump_en_reg;
        ins_en_next     = ins_en_reg;
        ins_idx_next    = ins_idx_reg;
        new_rank_next   = new_rank_reg;
        hit_next        = hit_reg;
        ev_valid_next   = ev_valid_reg;
        ev_key_next     = ev_key_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = rd_pos_reg;
        wr_data         = {nv, nk, nc, nr};
        res_push        = 1'b0;

        if (scan_take)
        begin
            if (rd_valid && (rd_key == key_reg))
            begin
                found_next  = 1'b1;
                s_idx_next  = rd_pos_reg;
                s_rank_next = rd_rank;
            end
            if (!rd_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = rd_pos_reg;
            end
            if (beats)
            begin
                vic_found_next = 1'b1;
                vic_idx_next   = rd_pos_reg;
                vic_count_next = rd_count;
                vic_rank_next  = rd_rank;
                vic_key_next   = rd_key;
            end
        end

        if (upd_take)
        begin
            wr_en = 1'b1;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = addr_reg;
                wr_data = '0;
                if (addr_reg == IDX_LAST)
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + IDX_BITS'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next        = start_cmd;
                    key_next        = start_key;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    vic_found_next  = 1'b0;
                    addr_next       = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN, ST_UPDATE:
            begin
                rd_en = 1'b1;
                if (addr_reg == IDX_LAST)
                begin
                    addr_next  = '0;
                    state_next = (state_reg == ST_SCAN) ? ST_SCAN_END : ST_UPD_END;
                end
                else
                begin
                    addr_next = addr_reg + IDX_BITS'(1);
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                close_en_next   = 1'b0;
                close_rank_next = s_rank_reg;
                kill_en_next    = 1'b0;
                kill_idx_next   = s_idx_reg;
                bump_en_next    = 1'b0;
                ins_en_next     = 1'b0;
                ins_idx_next    = free_idx_reg;
                new_rank_next   = RANK_BITS'(total_reg - OCC_BITS'(1));
                hit_next        = found_reg;
                ev_valid_next   = 1'b0;
                ev_key_next     = '0;
                if (cmd_reg == CMD_REMOVE)
                begin
                    if (found_reg)
                    begin
                        close_en_next = 1'b1;
                        kill_en_next  = 1'b1;
                        total_next    = total_reg - OCC_BITS'(1);
                    end
                end
                else if (found_reg)
                begin
                    close_en_next = 1'b1;
                    bump_en_next  = 1'b1;
                end
                else if (must_evict)
                begin
                    ev_valid_next = 1'b1;
                    if (vic_ok)
                    begin
                        ev_key_next     = vic_key_reg;
                        close_en_next   = 1'b1;
                        close_rank_next = vic_rank_reg;
                        kill_en_next    = 1'b1;
                        kill_idx_next   = vic_idx_reg;
                        ins_en_next     = 1'b1;
                        ins_idx_next    = slot_for_ins;
                    end
                    else
                    begin
                        ev_key_next = key_reg;
                    end
                end
                else
                begin
                    ins_en_next   = 1'b1;
                    new_rank_next = RANK_BITS'(total_reg);
                    total_next    = total_reg + OCC_BITS'(1);
                end
                addr_next  = '0;
                state_next = ST_UPDATE;
            end
            ST_UPD_END:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (res_ready)
                begin
                    res_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rd_vld_next = rd_en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
            total_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            rd_vld_reg <= rd_vld_next;
            total_reg  <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_pos_reg     <= rd_pos_next;
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        found_reg      <= found_next;
        s_idx_reg      <= s_idx_next;
        s_rank_reg     <= s_rank_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        vic_found_reg  <= vic_found_next;
        vic_idx_reg    <= vic_idx_next;
        vic_count_reg  <= vic_count_next;
        vic_rank_reg   <= vic_rank_next;
        vic_key_reg    <= vic_key_next;
        close_en_reg   <= close_en_next;
        close_rank_reg <= close_rank_next;
        kill_en_reg    <= kill_en_next;
        kill_idx_reg   <= kill_idx_next;
        bump_en_reg    <= bump_en_next;
        ins_en_reg     <= ins_en_next;
        ins_idx_reg    <= ins_idx_next;
        new_rank_reg   <= new_rank_next;
        hit_reg        <= hit_next;
        ev_valid_reg   <= ev_valid_next;
        ev_key_reg     <= ev_key_next;
    end

    assign busy              = (state_reg != ST_IDLE);
    assign total             = total_reg;
    assign res.hit           = hit_reg;
    assign res.evicted_valid = ev_valid_reg;
    assign res.evict_key     = KEY_PORT_BITS'(ev_key_reg);

endmodule

// ----- hdl/lfu_lru_tiebreak_replacement.sv -----
// Top level of the LFU replacement tracker with LRU tie-break.
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_valid / req_stall): cmd selects access or remove,
//   object_key names the object; a request is taken at a clock edge with
//   req_valid high and req_stall low.
//   Response channel (rsp_valid / rsp_stall): one response per request with
//   hit, evicted_valid, evict_key and the occupancy after the request.
//   Configuration channel (cfg_valid / cfg_ready, always ready): writes
//   capacity_in_use; write it only while no request is in flight.
// Operation:
//   One sweep over the table RAM finds the key, the first free slot and the
//   victim, a read-modify-write sweep fixes counts and ranks. req_stall stays
//   high while a request is in work, so a new request is taken only after
//   the previous one has handed its result to the response register.
// Reset:
//   A clearing sweep invalidates the table after rst_n releases, with
//   req_stall high. Capacity resets to 64.
// Receiver stall:
//   Hold the response register while rsp_stall is high. The next request may
//   be accepted and worked on meanwhile; its result waits for the register.
module lfu_lru_tiebreak_replacement
    import lflr_pkg::*;
#(
    parameter int ENTRIES    = LFLR_ENTRIES,
    parameter int COUNT_BITS = LFLR_COUNT_BITS,
    parameter int KEY_BITS   = LFLR_KEY_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic                          cmd,
    input  logic [KEY_PORT_BITS-1:0]      object_key,
    // response channel
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic                          hit,
    output logic                          evicted_valid,
    output logic [KEY_PORT_BITS-1:0]      evict_key,
    output logic [$clog2(ENTRIES+1)-1:0]  occupancy,
    // configuration channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CAP_BITS-1:0]           capacity_in_use
);

    localparam int OCC_BITS = $clog2(ENTRIES + 1);
    // Common width for clamping the capacity against the table size
    localparam int CW = ((OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS) + 1;

    logic [CAP_BITS-1:0] cap_reg, cap_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic                hit_reg;
    logic                ev_valid_reg;
    logic [KEY_PORT_BITS-1:0] ev_key_reg;
    logic [OCC_BITS-1:0] occ_reg;

    logic [CW-1:0]       cap_ext;
    logic [OCC_BITS-1:0] eff_cap;
    logic                busy;
    logic                start;
    logic                res_ready;
    logic                res_push;
    lflr_res_t           res;
    logic [OCC_BITS-1:0] total;

    assign cfg_ready = 1'b1;
    assign req_stall = busy;
    assign start     = req_valid && !busy;

    // Clamp capacity: zero acts as one, anything above the table acts as full
    assign cap_ext = CW'(cap_reg);
    always_comb
    begin
        if (cap_ext == '0)
        begin
            eff_cap = OCC_BITS'(1);
        end
        else if (cap_ext > CW'(ENTRIES))
        begin
            eff_cap = OCC_BITS'(ENTRIES);
        end
        else
        begin
            eff_cap = OCC_BITS'(cap_ext);
        end
    end

    lflr_engine #(
        .ENTRIES   (ENTRIES),
        .COUNT_BITS(COUNT_BITS),
        .KEY_BITS  (KEY_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .start_cmd(cmd),
        .start_key(object_key[KEY_BITS-1:0]),
        .busy     (busy),
        .eff_cap  (eff_cap),
        .res_ready(res_ready),
        .res_push (res_push),
        .res      (res),
        .total    (total)
    );

    // The response register takes a new result when empty or being drained
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_valid && cfg_ready)
        begin
            cap_next = capacity_in_use;
        end

        rsp_valid_next = rsp_valid_reg;
        if (res_push)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Load the response payload with each finished request
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            hit_reg      <= res.hit;
            ev_valid_reg <= res.evicted_valid;
            ev_key_reg   <= res.evict_key;
            occ_reg      <= total;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign hit           = hit_reg;
    assign evicted_valid = ev_valid_reg;
    assign evict_key     = ev_key_reg;
    assign occupancy     = occ_reg;

endmodule

// ----- verif/tb_lfu_lru_tiebreak_replacement.sv -----
// Self-checking testbench for the LFU replacement tracker with LRU tie-break.
`timescale 1ns / 1ps

module tb_lfu_lru_tiebreak_replacement
    import lflr_pkg::*;
();

    typedef struct packed {
        lflr_res_t            res;
        logic [CAP_BITS-1:0]  occupancy;
    } cache_outcome_t;

    // Shadow copy of the tracker table; predicts one outcome per request
    class lfu_table_model;
        bit                       slot_valid [LFLR_ENTRIES];
        logic [KEY_PORT_BITS-1:0] slot_key   [LFLR_ENTRIES];
        longint unsigned          slot_count [LFLR_ENTRIES];
        int unsigned              slot_rank  [LFLR_ENTRIES];
        int unsigned              filled;
        int unsigned              capacity;
        longint unsigned          count_ceiling;
        cache_outcome_t           pending_outcomes [$];
        int mismatches, requests, hits, evictions, self_evictions, removes;

        function new();
            for (int i = 0; i < LFLR_ENTRIES; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_key[i]   = '0;
                slot_count[i] = 0;
                slot_rank[i]  = 0;
            end
            filled         = 0;
            capacity       = CAP_RESET;
            count_ceiling  = (64'd1 << LFLR_COUNT_BITS) - 1;
            mismatches     = 0;
            requests       = 0;
            hits           = 0;
            evictions      = 0;
            self_evictions = 0;
            removes        = 0;
        endfunction

        function void set_capacity(logic [CAP_BITS-1:0] value);
            capacity = value;
        endfunction

        function int outstanding();
            return pending_outcomes.size();
        endfunction

        function int locate(logic [KEY_PORT_BITS-1:0] key);
            for (int i = 0; i < LFLR_ENTRIES; i++)
                if (slot_valid[i] && slot_key[i] == key)
                    return i;
            return -1;
        endfunction

        function void close_ranks_above(int unsigned rank);
            for (int i = 0; i < LFLR_ENTRIES; i++)
                if (slot_valid[i] && slot_rank[i] > rank)
                    slot_rank[i]--;
        endfunction

        function void free_slot(int s);
            slot_valid[s] = 1'b0;
            close_ranks_above(slot_rank[s]);
            filled--;
        endfunction

        function void note_request(logic req_cmd, logic [KEY_PORT_BITS-1:0] key);
            int             s;
            int             victim;
            int unsigned    limit;
            bit             must_evict;
            cache_outcome_t o;
            s = locate(key);
            o.res.hit           = (s >= 0);
            o.res.evicted_valid = 1'b0;
            o.res.evict_key     = '0;
            if (req_cmd == CMD_REMOVE)
            begin
                removes++;
                if (s >= 0)
                    free_slot(s);
            end
            else if (s >= 0)
            begin
                if (slot_count[s] < count_ceiling)
                    slot_count[s]++;
                close_ranks_above(slot_rank[s]);
                slot_rank[s] = filled - 1;
            end
            else
            begin
                limit = capacity;
                if (limit < 1)
                    limit = 1;
                if (limit > LFLR_ENTRIES)
                    limit = LFLR_ENTRIES;
                must_evict = (filled + 1) > limit;
                victim     = -1;
                if (must_evict)
                begin
                    for (int i = 0; i < LFLR_ENTRIES; i++)
                    begin
                        if (!slot_valid[i])
                            continue;
                        if (victim < 0 || slot_count[i] < slot_count[victim] ||
                            (slot_count[i] == slot_count[victim] &&
                             slot_rank[i] < slot_rank[victim]))
                            victim = i;
                    end
                    // the newcomer has count 1 and is newest, so it only loses
                    // when every resident entry has been used more than once
                    if (victim >= 0 && slot_count[victim] > 1)
                        victim = -1;
                    o.res.evicted_valid = 1'b1;
                    evictions++;
                    if (victim < 0)
                    begin
                        o.res.evict_key = key;
                        self_evictions++;
                    end
                    else
                    begin
                        o.res.evict_key = slot_key[victim];
                        free_slot(victim);
                    end
                end
                if (!(must_evict && victim < 0))
                begin
                    for (int i = 0; i < LFLR_ENTRIES; i++)
                    begin
                        if (!slot_valid[i])
                        begin
                            slot_valid[i] = 1'b1;
                            slot_key[i]   = key;
                            slot_count[i] = 1;
                            slot_rank[i]  = filled;
                            filled++;
                            break;
                        end
                    end
                end
            end
            o.occupancy = CAP_BITS'(filled);
            pending_outcomes.push_back(o);
            requests++;
            if (o.res.hit)
                hits++;
        endfunction

        function void check_response(logic got_hit, logic got_ev_valid,
                                     logic [KEY_PORT_BITS-1:0] got_ev_key,
                                     logic [CAP_BITS-1:0] got_occupancy);
            cache_outcome_t want;
            if (pending_outcomes.size() == 0)
            begin
                $error("response with no request waiting: hit %0d, evict_key %0h",
                       got_hit, got_ev_key);
                mismatches++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (got_hit !== want.res.hit)
            begin
                $error("hit: expected %0d, got %0d", want.res.hit, got_hit);
                mismatches++;
            end
            if (got_ev_valid !== want.res.evicted_valid)
            begin
                $error("evicted_valid: expected %0d, got %0d",
                       want.res.evicted_valid, got_ev_valid);
                mismatches++;
            end
            if (got_ev_key !== want.res.evict_key)
            begin
                $error("evict_key: expected %0h, got %0h", want.res.evict_key, got_ev_key);
                mismatches++;
            end
            if (got_occupancy !== want.occupancy)
            begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got_occupancy);
                mismatches++;
            end
        endfunction
    endclass

    localparam int KEY_POOL    = 100;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 128;
    localparam int DRAIN_SLACK = 2 * LFLR_ENTRIES + 10;

    // Capacity per random phase, phase 0 in the low bits. Zero acts as one,
    // 127 as the full table; 1 after 127 lowers capacity below occupancy.
    localparam logic [PHASES-1:0][CAP_BITS-1:0] PHASE_CAPS =
        {7'd2, 7'd64, 7'd0, 7'd8, 7'd40, 7'd1, 7'd127, 7'd16, 7'd3, 7'd64};

    logic                          clk   = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid;
    logic                          req_stall;
    logic                          cmd;
    logic [KEY_PORT_BITS-1:0]      object_key;
    logic                          rsp_valid;
    logic                          rsp_stall;
    logic                          hit;
    logic                          evicted_valid;
    logic [KEY_PORT_BITS-1:0]      evict_key;
    logic [CAP_BITS-1:0]           occupancy;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [CAP_BITS-1:0]           capacity_in_use;

    lfu_table_model           lfu_table;
    logic [KEY_PORT_BITS-1:0] key_pool [KEY_POOL];
    bit                       quiet_phase     = 1'b0;  // no idling on either side
    int                       hold_off_cycles = 0;     // long receiver stall, one shot
    int                       settings_used   = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    lfu_lru_tiebreak_replacement u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .cmd             (cmd),
        .object_key      (object_key),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .hit             (hit),
        .evicted_valid   (evicted_valid),
        .evict_key       (evict_key),
        .occupancy       (occupancy),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .capacity_in_use (capacity_in_use)
    );

    // Offer one request after a random gap; hold it until the block takes it.
    // Leave req_valid high afterwards so a zero gap gives back-to-back requests.
    task automatic send_request(input logic req_cmd, input logic [KEY_PORT_BITS-1:0] req_key);
        int gap;
        gap = quiet_phase ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid  <= 1'b1;
        cmd        <= req_cmd;
        object_key <= req_key;
        do @(posedge clk); while (req_stall);
        lfu_table.note_request(req_cmd, req_key);
    endtask

    // Drop valid and pause until every predicted response has come back
    task automatic drain_responses();
        req_valid <= 1'b0;
        while (lfu_table.outstanding() != 0)
            @(posedge clk);
    endtask

    // Write the capacity register; only called with nothing in flight
    task automatic write_capacity(input logic [CAP_BITS-1:0] value);
        cfg_valid       <= 1'b1;
        capacity_in_use <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        lfu_table.set_capacity(value);
        settings_used++;
    endtask

    // One random phase: keys mostly from a window a bit wider than the
    // capacity so hits and evictions both happen; a few hot keys build up
    // counts above one, a few keys are pure noise.
    task automatic run_phase(input logic [CAP_BITS-1:0] cap, input bit quiet, input bit with_hold);
        int                       limit;
        int                       span;
        int                       pick;
        logic                     req_cmd;
        logic [KEY_PORT_BITS-1:0] req_key;
        drain_responses();
        write_capacity(cap);
        quiet_phase = quiet;
        limit = (cap < 1) ? 1 : ((cap > LFLR_ENTRIES) ? LFLR_ENTRIES : int'(cap));
        span  = limit + limit / 2 + 2;
        if (span > KEY_POOL - 1)
            span = KEY_POOL - 1;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            // stall the receiver for a long stretch while requests keep coming
            if (with_hold && i == 20)
                hold_off_cycles = 600;
            pick    = $urandom_range(0, 99);
            req_cmd = ($urandom_range(0, 99) < 15) ? CMD_REMOVE : CMD_ACCESS;
            if (pick < 5)
                req_key = {$urandom, $urandom};
            else if (pick < 35)
                req_key = key_pool[$urandom_range(0, 3)];
            else
                req_key = key_pool[$urandom_range(0, span)];
            send_request(req_cmd, req_key);
        end
        quiet_phase = 1'b0;
    endtask

    // Response side: stall at random before each response, honor a long
    // hold-off when one is requested, and check each accepted response.
    initial
    begin : response_side
        int stall_cycles;
        rsp_stall <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            stall_cycles = quiet_phase ? 0 : $urandom_range(0, 7);
            if (stall_cycles > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
            lfu_table.check_response(hit, evicted_valid, evict_key, occupancy);
        end
    end

    initial
    begin : stimulus
        req_valid       <= 1'b0;
        cmd             <= CMD_ACCESS;
        object_key      <= '0;
        cfg_valid       <= 1'b0;
        capacity_in_use <= CAP_RESET;
        lfu_table = new();

        // Key extremes and alternating bit patterns up front, random keys after
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        key_pool[3] = 64'h0000_0000_0000_0001;
        key_pool[4] = 64'h5555_5555_5555_5555;
        key_pool[5] = 64'hAAAA_AAAA_AAAA_AAAA;
        for (int i = 6; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: hits, misses, removes of present and absent keys
        write_capacity(7'd64);
        send_request(CMD_ACCESS, key_pool[0]);
        send_request(CMD_ACCESS, key_pool[1]);
        send_request(CMD_ACCESS, key_pool[0]);
        send_request(CMD_REMOVE, key_pool[2]);
        send_request(CMD_REMOVE, key_pool[1]);
        send_request(CMD_ACCESS, key_pool[1]);
        send_request(CMD_ACCESS, key_pool[2]);
        send_request(CMD_ACCESS, key_pool[3]);

        // Capacity zero acts as one and sits below occupancy: a miss evicts
        // the oldest count-one entry, occupancy stays, a hit evicts nothing
        drain_responses();
        write_capacity(7'd0);
        send_request(CMD_ACCESS, key_pool[4]);
        send_request(CMD_ACCESS, key_pool[0]);
        send_request(CMD_REMOVE, key_pool[0]);
        send_request(CMD_REMOVE, key_pool[2]);
        send_request(CMD_REMOVE, key_pool[3]);
        send_request(CMD_REMOVE, key_pool[4]);
        // Resident key used twice, so the newcomer evicts itself
        send_request(CMD_ACCESS, key_pool[5]);
        send_request(CMD_ACCESS, key_pool[5]);
        send_request(CMD_ACCESS, key_pool[4]);
        send_request(CMD_REMOVE, key_pool[5]);

        // Capacity above the table size acts as the table size
        drain_responses();
        write_capacity(7'd127);
        send_request(CMD_ACCESS, key_pool[1]);
        send_request(CMD_ACCESS, key_pool[0]);
        send_request(CMD_ACCESS, key_pool[1]);
        send_request(CMD_REMOVE, key_pool[1]);

        // Random phases; some without idling, one with the long receiver hold
        for (int p = 0; p < PHASES; p++)
            run_phase(PHASE_CAPS[p], (p == 2 || p == 3 || p == 7), (p == 2));

        drain_responses();
        repeat (DRAIN_SLACK) @(posedge clk);

        $display("Checked %0d requests over %0d capacity settings: %0d hits, %0d removes,",
                 lfu_table.requests, settings_used, lfu_table.hits, lfu_table.removes);
        $display("%0d evictions, %0d of them the newly missed key itself.",
                 lfu_table.evictions, lfu_table.self_evictions);
        if (lfu_table.mismatches == 0 && lfu_table.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: several times the slowest legal run
    initial
    begin : watchdog
        #12_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/lflr_pkg.sv
hdl/lflr_ram.sv
hdl/lflr_engine.sv
hdl/lfu_lru_tiebreak_replacement.sv
verif/tb_lfu_lru_tiebreak_replacement.sv
